/* rtl/core/plim_pkg.sv */
// Package for the piecewise linear interest map.
// Widths, knot count and the record that passes from the front part to the back part.
package plim_pkg;
  localparam int ValueWidth = 32;
  localparam int YWidth = 16;
  localparam int Knots = 6;
  localparam int KnotWidth = ValueWidth + YWidth;
  localparam int MagWidth = YWidth + 1;          // |dy| fits 17 bits
  localparam int DistWidth = ValueWidth + 1;     // x differences fit 33 bits
  localparam int QDepth = 4;
  localparam int QPtrWidth = 2;
  localparam int Steps = MagWidth;               // one quotient bit per stage

  localparam logic [2:0] RegEnable = 3'd6;

  // classified item: segment picked, operands ready for the divider
  typedef struct packed {
    logic                        missing;
    logic                        interp;   // 0: result is y_base directly
    logic                        neg;      // dy < 0
    logic signed [YWidth-1:0]    y_base;
    logic [MagWidth-1:0]         m;
    logic [DistWidth-1:0]        a;
    logic [DistWidth-1:0]        d;
  } job_t;

  typedef struct packed {
    logic                        missing;
    logic signed [YWidth-1:0]    interest;
  } res_t;
endpackage

/* rtl/core/plim_front.sv */
// Front part: compares the sample with the knots and builds a divider job.
// Uses plim_pkg. Two register stages: compare, then operand setup.
module plim_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                advance,
  input  logic signed [plim_pkg::ValueWidth-1:0] value,
  input  logic                                missing,
  input  logic [plim_pkg::KnotWidth-1:0]      knot [plim_pkg::Knots],
  input  logic                                enabled,
  output logic                                job_valid,
  output plim_pkg::job_t                      job
);
  import plim_pkg::*;

  logic                          s1_valid;
  logic                          s1_missing;
  logic                          s1_low;
  logic                          s1_high;
  logic [2:0]                    s1_k;
  logic signed [ValueWidth-1:0]  s1_v;
  logic [Knots-1:0]              le;
  logic [2:0]                    k_sel;

  logic signed [ValueWidth-1:0]  xk, xp;
  logic signed [YWidth-1:0]      yk, yp;
  logic signed [YWidth:0]        dy;

  always_comb begin
    for (int i = 0; i < Knots; i++) begin
      le[i] = value <= $signed(knot[i][KnotWidth-1:YWidth]);
    end
    k_sel = 3'(Knots - 1);
    for (int i = Knots - 1; i >= 1; i--) begin
      if (le[i]) k_sel = 3'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      job_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      job_valid <= s1_valid;
    end
    if (advance) begin
      s1_missing <= missing | ~enabled;
      s1_low <= le[0];
      // above every knot from two on: no segment matches
      s1_high <= ~|le[Knots-1:1];
      s1_k <= k_sel;
      s1_v <= value;
    end
    if (advance) begin
      job.missing <= s1_missing;
      job.interp <= ~(s1_low | s1_high);
      job.neg <= dy[YWidth];
      job.y_base <= s1_low ? $signed(knot[0][YWidth-1:0]) :
                    s1_high ? $signed(knot[Knots-1][YWidth-1:0]) : yk;
      job.m <= dy[YWidth] ? MagWidth'(-dy) : MagWidth'(dy);
      job.a <= DistWidth'({xk[ValueWidth-1], xk} - {s1_v[ValueWidth-1], s1_v});
      job.d <= DistWidth'({xk[ValueWidth-1], xk} - {xp[ValueWidth-1], xp});
    end
  end

  always_comb begin
    xk = $signed(knot[s1_k][KnotWidth-1:YWidth]);
    xp = $signed(knot[s1_k - 3'd1][KnotWidth-1:YWidth]);
    yk = $signed(knot[s1_k][YWidth-1:0]);
    yp = $signed(knot[s1_k - 3'd1][YWidth-1:0]);
    dy = {yk[YWidth-1], yk} - {yp[YWidth-1], yp};
  end
endmodule

/* rtl/core/plim_queue.sv */
// Small FIFO between the front and back parts.
// Uses plim_pkg job_t; registers only, one write and one read a cycle.
module plim_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  plim_pkg::job_t  wdata,
  input  logic            rd,
  output logic            empty,
  output logic [plim_pkg::QPtrWidth:0] count,
  output plim_pkg::job_t  rdata
);
  import plim_pkg::*;

  job_t                 mem [QDepth];
  logic [QPtrWidth-1:0] wp, rp;

  assign empty = count == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (QPtrWidth+1)'(wr) - (QPtrWidth+1)'(rd);
    end
    if (wr) mem[wp] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr && !rd |-> count < (QPtrWidth+1)'(QDepth))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty) else $error("queue underflow");
endmodule

/* rtl/core/plim_back.sv */
// Back part: pipelined restoring divider, floor(m*a/d), one quotient bit per stage.
// Uses plim_pkg. Stalls as a whole when the output is held.
module plim_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            job_valid,
  input  plim_pkg::job_t  job,
  output logic            res_valid,
  output plim_pkg::res_t  res
);
  import plim_pkg::*;

  logic [Steps:0]          v;
  job_t                    st_job [Steps+1];
  logic [DistWidth:0]      st_r   [Steps+1];
  logic [MagWidth-1:0]     st_q   [Steps+1];
  logic [DistWidth:0]      r_n    [Steps];
  logic [MagWidth-1:0]     q_n    [Steps];
  logic signed [YWidth-1:0] qs;

  assign v[0] = job_valid;
  assign st_job[0] = job;
  assign st_r[0] = '0;
  assign st_q[0] = '0;

  always_comb begin
    for (int s = 0; s < Steps; s++) begin
      logic [DistWidth+1:0] r2;
      logic [MagWidth-1:0] q2;
      r2 = {st_r[s], 1'b0};
      q2 = {st_q[s][MagWidth-2:0], 1'b0};
      if (r2 >= {1'b0, st_job[s].d}) begin
        r2 = r2 - {1'b0, st_job[s].d};
        q2 = q2 + 1'b1;
      end
      if (st_job[s].m[Steps-1-s]) begin
        r2 = r2 + {1'b0, st_job[s].a};
        if (r2 >= {1'b0, st_job[s].d}) begin
          r2 = r2 - {1'b0, st_job[s].d};
          q2 = q2 + 1'b1;
        end
      end
      r_n[s] = r2[DistWidth:0];
      q_n[s] = q2;
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (advance) v[s+1] <= v[s];
      if (advance) begin
        st_job[s+1] <= st_job[s];
        st_r[s+1] <= r_n[s];
        st_q[s+1] <= q_n[s];
      end
    end
  end

  assign qs = $signed(st_q[Steps][YWidth-1:0]);

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (advance) res_valid <= v[Steps];
    if (advance) begin
      res.missing <= st_job[Steps].missing;
      res.interest <= st_job[Steps].missing ? '0 :
                      !st_job[Steps].interp ? st_job[Steps].y_base :
                      st_job[Steps].neg ? st_job[Steps].y_base + qs :
                      st_job[Steps].y_base - qs;
    end
  end
endmodule

/* rtl/core/piecewise_linear_interest_map_top.sv */
// Top level of the six-knot piecewise linear interest map.
// Uses plim_pkg, plim_front, plim_queue, plim_back; holds the APB registers.
//
// Usage:
//  - s_axis: one beat per sample. tdata[31:0] = sample_value (Q16.16),
//    tuser[0] = sample_missing.
//  - m_axis: one beat per sample, same order. tdata[15:0] = interest (Q1.14),
//    tuser[0] = interest_missing.
//  - APB: knots at 0x00..0x28 (x in bits 47:16, y in 15:0), enable at 0x30.
//    Write only while the stream is idle.
// Throughput: one sample per cycle while m_axis_tready is high. A sample
// passes 2 front stages, the queue entry, 17 divider stages (one quotient
// bit each) and an output register.
// The front stages stall only when the queue holds two entries; the divider
// pipe and output register stall as one when m_axis_tready is low while
// m_axis_tvalid is high, and the queue absorbs the front's in-flight beats.
// s_axis_tready drops when the queue holds two entries.
// Reset clears all valid state and every APB register to zero (disabled).
module piecewise_linear_interest_map_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
  input  logic        s_axis_tuser,   // [0] sample_missing
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] interest
  output logic        m_axis_tuser,   // [0] interest_missing
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import plim_pkg::*;

  logic [KnotWidth-1:0] knot [Knots];
  logic                 enabled;
  logic [2:0]           reg_idx;
  logic                 front_go, back_go, job_valid, q_empty, res_valid;
  logic [QPtrWidth:0]   q_count;
  job_t                 job_in, job_out;
  res_t                 res;

  assign pready = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Knots; i++) knot[i] <= '0;
      enabled <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == RegEnable) enabled <= pwdata[0];
      else if (reg_idx < 3'(Knots)) knot[reg_idx] <= pwdata[KnotWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == RegEnable) prdata = {63'd0, enabled};
    else if (reg_idx < 3'(Knots)) prdata = 64'(knot[reg_idx]);
  end

  // front may move while queue holds at most one entry: two in flight fit
  assign front_go = q_count <= (QPtrWidth+1)'(1);
  assign s_axis_tready = front_go;
  // output register frees when empty or taken
  assign back_go = !m_axis_tvalid || m_axis_tready;

  plim_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .advance(front_go),
    .value(s_axis_tdata), .missing(s_axis_tuser), .knot, .enabled,
    .job_valid, .job(job_in)
  );

  plim_queue u_queue (
    .clk, .rst, .wr(job_valid && front_go), .wdata(job_in),
    .rd(back_go && !q_empty), .empty(q_empty), .count(q_count), .rdata(job_out)
  );

  plim_back u_back (
    .clk, .rst, .advance(back_go), .job_valid(!q_empty), .job(job_out),
    .res_valid, .res
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata = res.interest;
  assign m_axis_tuser = res.missing;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("missing result not zero");
  a_disabled: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |-> front_go)
    else $error("accept without front advance");
endmodule
